>>> hdl/ssi_pkg.sv
package ssi_pkg;

   localparam int unsigned KeyW = 16;
   localparam int unsigned TagW = 16;
   localparam int unsigned OccW = 7;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_POP    = 1'b1;

   typedef struct packed {
      logic            action;
      logic [KeyW-1:0] key;
      logic [TagW-1:0] tag;
   } ssi_req_type;

   typedef struct packed {
      logic            done_res;
      logic [KeyW-1:0] out_key;
      logic [TagW-1:0] out_tag;
      logic [OccW-1:0] occupancy;
   } ssi_rsp_type;

   typedef struct packed {
      logic [KeyW-1:0] key;
      logic [TagW-1:0] tag;
   } ssi_rec_type;

   // broadcast to every cell for one transaction
   typedef struct packed {
      logic        ins;
      logic        pop;
      ssi_rec_type rec;
   } ssi_ctl_type;

endpackage

>>> hdl/ssi_cell.sv
module ssi_cell (
   input  logic                clock,
   input  ssi_pkg::ssi_ctl_type ctl,
   input  logic                valid,
   input  logic                upper_gt,
   input  ssi_pkg::ssi_rec_type upper_rec,
   input  ssi_pkg::ssi_rec_type lower_rec,
   output logic                gt,
   output ssi_pkg::ssi_rec_type rec
);

   ssi_pkg::ssi_rec_type rec_ff;
   ssi_pkg::ssi_rec_type rec_in;

   assign gt  = valid && (rec_ff.key > ctl.rec.key);
   assign rec = rec_ff;

   always_comb begin
      rec_in = rec_ff;
      if (ctl.pop) begin
         rec_in = lower_rec;
      end else if (ctl.ins && !gt) begin
         if (upper_gt) begin
            rec_in = ctl.rec;
         end else begin
            rec_in = upper_rec;
         end
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

endmodule

>>> hdl/sorted_stack_insert_unit.sv
// Channel | Ports                              | Direction
// request | req_valid, req_ready, req_data    | in  (action, key, tag)
// response| rsp_valid, rsp_ready, rsp_data    | out (done_res, out_key, out_tag, occupancy)
//
// One transaction per cycle while no response stalls; each response is registered
// and appears in the next cycle. All cells compare the incoming key at once and shift.
// Synchronous reset empties the stack; no clearing pass is needed.
// A response held by rsp_ready low stalls new requests only while it waits.
module sorted_stack_insert_unit #(
   parameter int unsigned DEPTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ssi_pkg::ssi_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ssi_pkg::ssi_rsp_type rsp_data
);

   localparam int unsigned CntW = $clog2(DEPTH + 1);

   logic [CntW-1:0]      count_ff;
   logic [CntW-1:0]      count_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   ssi_pkg::ssi_rsp_type rsp_data_ff;
   ssi_pkg::ssi_rsp_type rsp_data_in;
   ssi_pkg::ssi_ctl_type ctl;
   logic                 accept;
   logic                 full;
   logic                 empty;

   logic                 gt  [DEPTH];
   ssi_pkg::ssi_rec_type rec [DEPTH];

   assign full      = (count_ff == CntW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign ctl = '{
      ins: accept && (req_data.action == ssi_pkg::ACT_INSERT) && !full,
      pop: accept && (req_data.action == ssi_pkg::ACT_POP) && !empty,
      rec: '{key: req_data.key, tag: req_data.tag}
   };

   // cell 0 holds the top of the stack
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      ssi_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .valid     (count_ff > CntW'(i)),
         .upper_gt  ((i == 0) ? 1'b1 : gt[(i == 0) ? 0 : i-1]),
         .upper_rec (rec[(i == 0) ? 0 : i-1]),
         .lower_rec ((i == DEPTH-1) ? ssi_pkg::ssi_rec_type'('0)
                                    : rec[(i == DEPTH-1) ? i : i+1]),
         .gt        (gt[i]),
         .rec       (rec[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.ins) begin
         count_in = count_ff + CntW'(1);
      end else if (ctl.pop) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.done_res  = ctl.ins || ctl.pop;
         rsp_data_in.out_key   = ctl.pop ? rec[0].key : '0;
         rsp_data_in.out_tag   = ctl.pop ? rec[0].tag : '0;
         rsp_data_in.occupancy = ssi_pkg::OccW'(count_in);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> hdl/ssi_checker.sv
module ssi_checker #(
   parameter int unsigned DEPTH = 64
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input ssi_pkg::ssi_rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_rsp_next: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("no response after accepted request");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.done_res |-> rsp_data.out_key == '0 && rsp_data.out_tag == '0)
      else $error("failed transaction carries a record");

   a_fail_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.done_res |->
         rsp_data.occupancy == '0 || rsp_data.occupancy == ssi_pkg::OccW'(DEPTH))
      else $error("failed transaction with stack neither empty nor full");

endmodule

bind sorted_stack_insert_unit ssi_checker #(.DEPTH(DEPTH)) u_ssi_checker (.*);
